[src/integer_to_base_digits_assert.svh]
// Assertion macros shared by the integer_to_base_digits RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef INTEGER_TO_BASE_DIGITS_ASSERT_SVH
`define INTEGER_TO_BASE_DIGITS_ASSERT_SVH

// Expression holds at every edge outside reset.
`define ITBD_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ITBD_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ITBD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/itbd_pkg.sv]
// Package for integer_to_base_digits: field widths, character codes,
// register indexes and the microcode table. No dependencies.
package itbd_pkg;

  localparam int VALUE_W       = 31;
  localparam int CHAR_W        = 8;
  localparam int REG_W         = 6;
  localparam int DIGIT_W       = 6;
  localparam int IDX_W         = 1;
  localparam int MAX_CHARS_DEF = 32;

  localparam logic [IDX_W-1:0] REG_RADIX     = 1'b0;
  localparam logic [IDX_W-1:0] REG_MIN_WIDTH = 1'b1;

  localparam logic [REG_W-1:0] RADIX_RESET     = 6'd10;
  localparam logic [REG_W-1:0] MIN_WIDTH_RESET = 6'd0;
  localparam logic [REG_W-1:0] RADIX_MIN       = 6'd2;
  localparam logic [REG_W-1:0] RADIX_MAX       = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  PAD_CHAR    = 8'h20;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR   = 8'h30;
  localparam logic [CHAR_W-1:0]  ALPHA_CHAR  = 8'h61;

  // Microcode step addresses
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t S_IDLE  = 3'd0;
  localparam step_t S_DIVI  = 3'd1;
  localparam step_t S_DIVS  = 3'd2;
  localparam step_t S_STORE = 3'd3;
  localparam step_t S_PADI  = 3'd4;
  localparam step_t S_PAD   = 3'd5;
  localparam step_t S_RD    = 3'd6;
  localparam step_t S_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    ACT_LOAD, ACT_DIV_INIT, ACT_DIV_STEP, ACT_STORE,
    ACT_PAD_INIT, ACT_PAD, ACT_READ, ACT_EMIT
  } act_t;

  // Stay on the current step while this condition is true
  typedef enum logic [1:0] {
    HOLD_NEVER, HOLD_NO_INPUT, HOLD_PAD, HOLD_OUT_BUSY
  } hold_t;

  // Jump to br_target when true, otherwise go to seq_target
  typedef enum logic [1:0] {
    BR_NEVER, BR_BITS_LEFT, BR_MORE_DIGITS, BR_MORE_CHARS
  } br_t;

  typedef struct packed {
    act_t  act;
    hold_t hold;
    br_t   br;
    step_t br_target;
    step_t seq_target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{ACT_LOAD,     HOLD_NO_INPUT, BR_NEVER,       S_IDLE, S_DIVI};
      S_DIVI:  w = '{ACT_DIV_INIT, HOLD_NEVER,    BR_NEVER,       S_DIVI, S_DIVS};
      S_DIVS:  w = '{ACT_DIV_STEP, HOLD_NEVER,    BR_BITS_LEFT,   S_DIVS, S_STORE};
      S_STORE: w = '{ACT_STORE,    HOLD_NEVER,    BR_MORE_DIGITS, S_DIVI, S_PADI};
      S_PADI:  w = '{ACT_PAD_INIT, HOLD_NEVER,    BR_NEVER,       S_PADI, S_PAD};
      S_PAD:   w = '{ACT_PAD,      HOLD_PAD,      BR_NEVER,       S_PAD,  S_RD};
      S_RD:    w = '{ACT_READ,     HOLD_NEVER,    BR_NEVER,       S_RD,   S_EMIT};
      S_EMIT:  w = '{ACT_EMIT,     HOLD_OUT_BUSY, BR_MORE_CHARS,  S_RD,   S_IDLE};
      default: w = '{ACT_LOAD,     HOLD_NO_INPUT, BR_NEVER,       S_IDLE, S_DIVI};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_LIMIT) begin
      c = ZERO_CHAR + CHAR_W'(d);
    end else begin
      c = ALPHA_CHAR + CHAR_W'(d - DIGIT_LIMIT);
    end
    return c;
  endfunction

endpackage

[src/itbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/integer_to_base_digits.sv]
// Top level of integer_to_base_digits: microcode sequencer and datapath.
// Uses itbd_pkg, itbd_ram and the assertion macro header.
`include "integer_to_base_digits_assert.svh"

// Converts each input value to ASCII digits in the configured radix (2..36,
// out-of-range settings clamp), most significant first, with leading spaces
// up to min_width (saturated at MAX_CHARS); the final character has tlast.
// Radix 10 and no padding after reset. Digits come from a restoring divider
// that retires one quotient bit per cycle; each digit takes an init step, one
// divide step per value bit and a store step. Then come a pad init step, a
// pad step for each pad character, and a read and an emit step per digit; the
// output side can stall the pad and emit steps. A new item is taken only once
// the last character of the previous one sits in the output register.
module integer_to_base_digits
  import itbd_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((VALUE_W+7)/8)*8-1:0]      s_tdata,   // [30:0] value
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [CHAR_W-1:0]                 m_tdata,   // [7:0] char_out
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [IDX_W-1:0]                  cfg_index,
  input  logic [REG_W-1:0]                  cfg_data
);

  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W = $clog2(MAX_CHARS);
  localparam int BIT_W  = $clog2(VALUE_W);

  logic [REG_W-1:0]   radix;
  logic [REG_W-1:0]   min_width;
  step_t              step, step_next;
  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;
  logic [BIT_W-1:0]   bitcnt;
  logic [CNT_W-1:0]   n, n_dec, pad, width_sat;
  logic [REG_W-1:0]   radix_eff;
  logic [DIGIT_W:0]   div_trial;
  logic               div_ge;
  uword_t             uw;
  logic               in_fire, out_free, hold, br_taken;
  logic               emit_pad, emit_dig;
  logic [DIGIT_W-1:0] rd_digit;

  assign uw       = ucode(step);
  assign s_tready = (uw.act == ACT_LOAD);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign n_dec    = n - CNT_W'(1);

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
    if (int'(min_width) > MAX_CHARS) begin
      width_sat = CNT_W'(MAX_CHARS);
    end else begin
      width_sat = CNT_W'(min_width);
    end
  end

  assign div_trial = {rem, quo[VALUE_W-1]};
  assign div_ge    = (div_trial >= {1'b0, radix_eff});

  always_comb begin
    case (uw.hold)
      HOLD_NO_INPUT: hold = !in_fire;
      HOLD_PAD:      hold = (pad != '0);
      HOLD_OUT_BUSY: hold = !out_free;
      default:       hold = 1'b0;
    endcase
    case (uw.br)
      BR_BITS_LEFT:   br_taken = (bitcnt != '0);
      BR_MORE_DIGITS: br_taken = (quo != '0) && (int'(n) + 1 < MAX_CHARS);
      BR_MORE_CHARS:  br_taken = (n != CNT_W'(1));
      default:        br_taken = 1'b0;
    endcase
    if (hold) begin
      step_next = step;
    end else if (br_taken) begin
      step_next = uw.br_target;
    end else begin
      step_next = uw.seq_target;
    end
  end

  assign emit_pad = (uw.act == ACT_PAD) && (pad != '0) && out_free;
  assign emit_dig = (uw.act == ACT_EMIT) && out_free;

  itbd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_CHARS)
  ) u_digits (
    .clk   (clk),
    .we    (uw.act == ACT_STORE),
    .waddr (n[ADDR_W-1:0]),
    .wdata (rem),
    .re    (uw.act == ACT_READ),
    .raddr (n_dec[ADDR_W-1:0]),
    .rdata (rd_digit)
  );

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      radix     <= RADIX_RESET;
      min_width <= MIN_WIDTH_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:     radix     <= cfg_data;
          REG_MIN_WIDTH: min_width <= cfg_data;
          default:       ;
        endcase
      end
      if (emit_pad || emit_dig) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      pad <= '0;
    end else begin
      case (uw.act)
        ACT_LOAD: begin
          if (in_fire) begin
            quo <= s_tdata[VALUE_W-1:0];
            n   <= '0;
          end
        end
        ACT_DIV_INIT: begin
          rem    <= '0;
          bitcnt <= BIT_W'(VALUE_W - 1);
        end
        ACT_DIV_STEP: begin
          // shift in the next dividend bit, subtract radix when it fits
          if (div_ge) begin
            rem <= DIGIT_W'(div_trial - {1'b0, radix_eff});
            quo <= {quo[VALUE_W-2:0], 1'b1};
          end else begin
            rem <= div_trial[DIGIT_W-1:0];
            quo <= {quo[VALUE_W-2:0], 1'b0};
          end
          bitcnt <= bitcnt - BIT_W'(1);
        end
        ACT_STORE: begin
          n <= n + CNT_W'(1);
        end
        ACT_PAD_INIT: begin
          pad <= (width_sat > n) ? (width_sat - n) : '0;
        end
        ACT_PAD: begin
          if (emit_pad) begin
            pad <= pad - CNT_W'(1);
          end
        end
        ACT_EMIT: begin
          if (emit_dig) begin
            n <= n_dec;
          end
        end
        default: ;
      endcase
    end
    if (emit_pad) begin
      m_tdata <= PAD_CHAR;
      m_tlast <= 1'b0;
    end else if (emit_dig) begin
      m_tdata <= digit_char(rd_digit);
      m_tlast <= (n == CNT_W'(1));
    end
  end

  `ITBD_NEXT(a_rem_below_radix, step == S_DIVS, rem < radix_eff, "remainder not below radix")
  `ITBD_SAME(a_emit_has_digit, step == S_EMIT, n != '0, "digit emit with empty digit store")
  `ITBD_ALWAYS(a_count_bound, int'(n) <= MAX_CHARS, "digit count beyond capacity")
  `ITBD_NEXT(a_accept_starts, in_fire, step == S_DIVI, "accepted item did not start division")
  `ITBD_SAME(a_last_no_pad, emit_dig && (n == CNT_W'(1)), pad == '0, "last char with pad left")

endmodule

[dv/tb.sv]
// Self-checking bench for integer_to_base_digits: streams values, predicts the
// padded digit strings per radix/width setting and checks every character.
// Depends on itbd_pkg and the integer_to_base_digits RTL.
module tb;
  import itbd_pkg::*;

  localparam int TDATA_W      = ((VALUE_W + 7) / 8) * 8;
  localparam int FLUSH_SETTLE = 6;
  localparam int STUCK_LIMIT  = 10000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 24;

  typedef enum logic [1:0] {FEED_VALUE, FEED_REG_WRITE, FEED_FLUSH} feed_kind_t;
  typedef enum logic [1:0] {SINK_FREE, SINK_HALF, SINK_SPARSE, SINK_CHOKED} sink_mode_t;

  typedef struct {
    feed_kind_t         kind;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    logic [REG_W-1:0]   data;
  } feed_op_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } char_exp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;   // [30:0] value
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [CHAR_W-1:0]  m_tdata;        // [7:0] char_out
  logic               m_tlast;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]   cfg_data = '0;

  feed_op_t  feed_q[$];
  char_exp_t expected_chars[$];

  // Register copies as the block holds them
  logic [REG_W-1:0] cur_radix = RADIX_RESET;
  logic [REG_W-1:0] cur_width = MIN_WIDTH_RESET;

  int          errors = 0;
  int unsigned stuck_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned settle_cnt = 0;
  sink_mode_t  sink_mode = SINK_FREE;
  int unsigned mode_left = 0;

  integer_to_base_digits uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Expand one value into the characters the block should send for it
  function automatic void predict_chars(logic [VALUE_W-1:0] v);
    logic [CHAR_W-1:0] digs[$];
    int unsigned       base;
    int unsigned       width;
    int unsigned       pad;
    int unsigned       total;
    int unsigned       d;
    longint unsigned   rest;
    char_exp_t         e;
    base = cur_radix;
    if (cur_radix < RADIX_MIN) base = RADIX_MIN;
    if (cur_radix > RADIX_MAX) base = RADIX_MAX;
    rest = v;
    do begin
      d = rest % base;
      if (d < DIGIT_LIMIT) begin
        digs.push_front(ZERO_CHAR + CHAR_W'(d));
      end else begin
        digs.push_front(ALPHA_CHAR + CHAR_W'(d - DIGIT_LIMIT));
      end
      rest = rest / base;
    end while (rest != 0);
    width = (cur_width > MAX_CHARS_DEF) ? MAX_CHARS_DEF : cur_width;
    pad = (width > digs.size()) ? width - digs.size() : 0;
    total = pad + digs.size();
    for (int k = 0; k < total; k++) begin
      e.ch = (k < pad) ? PAD_CHAR : digs[k - pad];
      e.is_last = (k + 1 == total);
      expected_chars.push_back(e);
    end
  endfunction

  // Random, small, shifted, all-ones and zero values, radix powers, neighbors
  function automatic logic [VALUE_W-1:0] rand_value(int unsigned base);
    longint unsigned    p;
    int unsigned        k;
    logic [VALUE_W-1:0] v;
    v = VALUE_W'($urandom);
    case ($urandom_range(0, 5))
      0: v = VALUE_W'($urandom_range(0, 2 * base));
      1: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * base <= 64'h7FFF_FFFF) begin
          p = p * base;
          k--;
        end
        v = ($urandom_range(0, 1) == 1) ? VALUE_W'(p) : VALUE_W'(p - 1);
      end
      2: v = v >> $urandom_range(1, 30);
      3: v = ($urandom_range(0, 1) == 1) ? {VALUE_W{1'b1}} : {VALUE_W{1'b0}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_value(logic [VALUE_W-1:0] v);
    feed_op_t op;
    op = '{FEED_VALUE, v, '0, '0};
    feed_q.push_back(op);
  endtask

  task automatic queue_flush();
    feed_op_t op;
    op = '{FEED_FLUSH, '0, '0, '0};
    feed_q.push_back(op);
  endtask

  // Registers change only once the block has gone quiet
  task automatic queue_setting(int unsigned rad, int unsigned wid);
    feed_op_t op;
    queue_flush();
    op = '{FEED_REG_WRITE, '0, REG_RADIX, REG_W'(rad)};
    feed_q.push_back(op);
    op = '{FEED_REG_WRITE, '0, REG_MIN_WIDTH, REG_W'(wid)};
    feed_q.push_back(op);
  endtask

  initial begin : stimulus
    int unsigned rad;
    int unsigned wid;
    int unsigned base;
    // Reset defaults: radix 10, no padding
    queue_value(31'd0);
    queue_value(31'd1);
    queue_value(31'd9);
    queue_value(31'd10);
    queue_value(31'h7FFF_FFFF);
    queue_value(31'd1000000000);
    queue_value(31'd12345);
    // Binary: longest digit strings
    queue_setting(2, 0);
    queue_value(31'd0);
    queue_value(31'd1);
    queue_value(31'h7FFF_FFFF);
    queue_value(31'h4000_0000);
    // Top radix with full-width padding
    queue_setting(36, 32);
    queue_value(31'd0);
    queue_value(31'd35);
    queue_value(31'd36);
    queue_value(31'h7FFF_FFFF);
    // Radix below two and width beyond capacity
    queue_setting(0, 63);
    queue_value(31'd5);
    queue_value(31'h7FFF_FFFF);
    queue_setting(1, 31);
    queue_value(31'h7FFF_FFFF);
    queue_value(31'd7);
    // Radix above thirty-six
    queue_setting(63, 1);
    queue_value(31'd0);
    queue_value(31'h7FFF_FFFF);
    queue_setting(37, 0);
    queue_value(31'd1295);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      rad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 36);
      wid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
      queue_setting(rad, wid);
      base = (rad < RADIX_MIN) ? RADIX_MIN : (rad > RADIX_MAX) ? RADIX_MAX : rad;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off mid-phase until the block has drained
        if (ph == 4 && k == PHASE_ITEMS / 2) queue_flush();
        queue_value(rand_value(base));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || s_tvalid || expected_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_proc
    logic               nxt_valid;
    logic [TDATA_W-1:0] nxt_data;
    logic               nxt_we;
    logic [IDX_W-1:0]   nxt_idx;
    logic [REG_W-1:0]   nxt_reg;
    nxt_valid = s_tvalid;
    nxt_data = s_tdata;
    nxt_we = 1'b0;
    nxt_idx = cfg_index;
    nxt_reg = cfg_data;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_chars(s_tdata[VALUE_W-1:0]);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && feed_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (feed_q[0].kind)
            FEED_VALUE: begin
              nxt_valid = 1'b1;
              nxt_data = '0;
              nxt_data[VALUE_W-1:0] = feed_q[0].value;
              void'(feed_q.pop_front());
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
              end
            end
            FEED_REG_WRITE: begin
              nxt_we = 1'b1;
              nxt_idx = feed_q[0].idx;
              nxt_reg = feed_q[0].data;
              if (feed_q[0].idx == REG_RADIX) begin
                cur_radix = feed_q[0].data;
              end else begin
                cur_width = feed_q[0].data;
              end
              void'(feed_q.pop_front());
            end
            default: begin
              // Wait for every character, then for the settle count to run out
              if (expected_chars.size() != 0) begin
                settle_cnt = 0;
              end else if (settle_cnt < FLUSH_SETTLE) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(feed_q.pop_front());
              end
            end
          endcase
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata <= nxt_data;
    cfg_we <= nxt_we;
    cfg_index <= nxt_idx;
    cfg_data <= nxt_reg;
  end

  always @(posedge clk) begin : sink_proc
    char_exp_t want;
    logic      nxt_ready;
    nxt_ready = m_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected item: char_out %h, last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.ch) begin
            $error("char_out mismatch: expected %h, actual %h", want.ch, m_tdata);
            errors++;
          end
          if (m_tlast !== want.is_last) begin
            $error("last mismatch: expected %b, actual %b", want.is_last, m_tlast);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_FREE:   nxt_ready = 1'b1;
        SINK_HALF:   nxt_ready = ($urandom_range(0, 1) == 1);
        SINK_SPARSE: nxt_ready = ($urandom_range(0, 4) == 0);
        default:     nxt_ready = ($urandom_range(0, 24) == 0);
      endcase
    end
    m_tready <= nxt_ready;
  end

  // Abort when nothing moves for far longer than the slowest item needs
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
